[hdl/tws_pkg.sv]
package tws_pkg;

    // field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned SET_W     = 3;
    localparam int unsigned ENT_W     = 4;
    localparam int unsigned START_W   = 20;
    localparam int unsigned DUR_W     = 16;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned IVAL_W    = 16;
    localparam int unsigned PASSED_W  = 16;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned WORD_W    = START_W + DUR_W;

    // parameter defaults
    localparam int unsigned SETS_DEF  = 4;
    localparam int unsigned FEEDS_DEF = 16;

    localparam logic [START_W-1:0]   START_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
    localparam logic [OP_W-1:0] OP_FILL    = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_FILL  = 5'b10000
    } state_t;

endpackage

[hdl/time_window_schedule_output_top.sv]
// time window schedule output
//
// command channel: a word is taken at a rising edge with start high and busy low;
// operation selects tick, restart, single entry write or cyclic fill of a set
// result channel: done is high for exactly one cycle and output_on is valid with it;
// every command gives exactly one result, and the receiver cannot stall
// output_on holds its value between results; only a tick recomputes it
// config: active_set is written on any edge with active_set_we high, no wait
//
// path from accept to done, all through one table port:
//   restart, or write/fill to a bad set or entry : done straight from idle
//   tick with active set zero or above SETS      : done straight from idle
//   single entry write                           : through the write state
//   cyclic fill                                  : every entry of the set, one a cycle
//   tick                                         : scan one entry a cycle, stops early
//                                                  on a hit, an empty entry or the end
// busy stays high until the cycle done is shown, so one command is in flight
// reset: counter, output and active_set clear, then a clearing pass writes zero
// to all SETS * FEEDS table entries, one a cycle, with busy high throughout
module time_window_schedule_output_top #(
    parameter int unsigned SETS  = tws_pkg::SETS_DEF,
    parameter int unsigned FEEDS = tws_pkg::FEEDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config
    input  logic                          active_set_we,
    input  logic [tws_pkg::SET_W-1:0]     active_set,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic [tws_pkg::OP_W-1:0]      operation,
    input  logic [tws_pkg::SET_W-1:0]     set_number,
    input  logic [tws_pkg::ENT_W-1:0]     entry_index,
    input  logic [tws_pkg::START_W-1:0]   start_time,
    input  logic [tws_pkg::DUR_W-1:0]     duration,
    input  logic [tws_pkg::COUNT_W-1:0]   entry_count,
    input  logic [tws_pkg::IVAL_W-1:0]    interval,
    input  logic [tws_pkg::PASSED_W-1:0]  seconds_passed,
    // result
    output logic                          done,
    output logic                          output_on
);
    import tws_pkg::*;

    localparam int unsigned DEPTH  = SETS * FEEDS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IDX_W  = $clog2(FEEDS);
    localparam int unsigned CNT_W  = $clog2(FEEDS + 1);

    // table, one word per entry: start time over duration
    logic [WORD_W-1:0] mem [DEPTH];

    state_t              state_reg,   state_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                flag_reg,    flag_next;
    logic                done_reg,    done_next;
    logic [SET_W-1:0]    aset_reg;
    logic [ADDR_W-1:0]   base_reg,    base_next;
    logic [ADDR_W-1:0]   clr_reg,     clr_next;
    logic [CNT_W-1:0]    iss_reg,     iss_next;
    logic [IDX_W-1:0]    chk_reg,     chk_next;
    logic                rdv_reg,     rdv_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [START_W-1:0]  t_reg,       t_next;
    logic [DUR_W-1:0]    dur_reg,     dur_next;
    logic [IVAL_W-1:0]   ival_reg,    ival_next;
    logic [IDX_W-1:0]    ent_reg,     ent_next;
    logic [WORD_W-1:0]   rd_data_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;

    logic                accept;
    logic                set_num_ok;
    logic                aset_ok;
    logic                ent_ok;
    logic [ADDR_W-1:0]   set_base;
    logic [ADDR_W-1:0]   aset_base;
    logic [ELAPSED_W:0]  tick_sum;
    logic [START_W:0]    fill_sum;
    logic [START_W-1:0]  ent_start;
    logic [DUR_W-1:0]    ent_dur;
    logic [START_W:0]    ent_end;
    logic                in_win;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign output_on = flag_reg;

    assign set_num_ok = (set_number != '0) && (32'(set_number) <= SETS);
    assign aset_ok    = (aset_reg != '0) && (32'(aset_reg) <= SETS);
    assign ent_ok     = (32'(entry_index) < FEEDS);
    assign set_base   = ADDR_W'((32'(set_number) - 32'd1) * 32'(FEEDS));
    assign aset_base  = ADDR_W'((32'(aset_reg) - 32'd1) * 32'(FEEDS));

    // saturating counter update for a tick
    assign tick_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(seconds_passed);
    // saturating start time step for cyclic fill
    assign fill_sum = {1'b0, t_reg} + (START_W + 1)'(ival_reg);

    // window compare on the entry read last cycle; the end never wraps
    assign ent_start = rd_data_reg[WORD_W-1:DUR_W];
    assign ent_dur   = rd_data_reg[DUR_W-1:0];
    assign ent_end   = {1'b0, ent_start} + (START_W + 1)'(ent_dur);
    assign in_win    = ((ELAPSED_W)'(ent_start) <= elapsed_reg)
                    && (elapsed_reg < (ELAPSED_W)'(ent_end));

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        flag_next    = flag_reg;
        done_next    = 1'b0;
        base_next    = base_reg;
        clr_next     = clr_reg;
        iss_next     = iss_reg;
        chk_next     = chk_reg;
        rdv_next     = 1'b0;
        cnt_next     = cnt_reg;
        t_next       = t_reg;
        dur_next     = dur_reg;
        ival_next    = ival_reg;
        ent_next     = ent_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_reg;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = base_reg + ADDR_W'(iss_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_TICK:
                        begin
                            elapsed_next = tick_sum[ELAPSED_W] ? ELAPSED_MAX
                                                               : tick_sum[ELAPSED_W-1:0];
                            if (aset_ok)
                            begin
                                base_next  = aset_base;
                                iss_next   = '0;
                                chk_next   = '0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                flag_next = 1'b0;
                                done_next = 1'b1;
                            end
                        end
                        OP_RESTART:
                        begin
                            elapsed_next = '0;
                            done_next    = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            if (set_num_ok && ent_ok)
                            begin
                                base_next  = set_base;
                                ent_next   = IDX_W'(entry_index);
                                t_next     = start_time;
                                dur_next   = duration;
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_FILL:
                        begin
                            if (set_num_ok)
                            begin
                                base_next = set_base;
                                // count clamps to FEEDS-1
                                cnt_next  = (32'(entry_count) >= FEEDS)
                                          ? CNT_W'(FEEDS - 1) : CNT_W'(entry_count);
                                t_next     = '0;
                                dur_next   = duration;
                                ival_next  = interval;
                                iss_next   = '0;
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle, check the entry read the cycle before
                if (32'(iss_reg) < FEEDS)
                begin
                    rd_en    = 1'b1;
                    iss_next = iss_reg + CNT_W'(1);
                end
                rdv_next = rd_en;
                if (rdv_reg)
                begin
                    if (ent_dur == '0)
                    begin
                        flag_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (in_win)
                    begin
                        flag_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (chk_reg == IDX_W'(FEEDS - 1))
                    begin
                        flag_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        chk_next = chk_reg + IDX_W'(1);
                    end
                end
            end
            ST_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = base_reg + ADDR_W'(ent_reg);
                wr_data    = {t_reg, dur_reg};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = base_reg + ADDR_W'(iss_reg);
                if (iss_reg < cnt_reg)
                begin
                    wr_data = {t_reg, dur_reg};
                    t_next  = fill_sum[START_W] ? START_MAX : fill_sum[START_W-1:0];
                end
                else
                begin
                    wr_data = '0;
                end
                iss_next = iss_reg + CNT_W'(1);
                if (iss_reg == CNT_W'(FEEDS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            elapsed_reg <= '0;
            flag_reg    <= 1'b0;
            done_reg    <= 1'b0;
            aset_reg    <= '0;
            clr_reg     <= '0;
            iss_reg     <= '0;
            chk_reg     <= '0;
            rdv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            flag_reg    <= flag_next;
            done_reg    <= done_next;
            clr_reg     <= clr_next;
            iss_reg     <= iss_next;
            chk_reg     <= chk_next;
            rdv_reg     <= rdv_next;
            if (active_set_we)
            begin
                aset_reg <= active_set;
            end
        end
    end

    // operands of the command in flight
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        t_reg    <= t_next;
        dur_reg  <= dur_next;
        ival_reg <= ival_next;
        ent_reg  <= ent_next;
    end

    // table: one write, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a result is never shown while a command is still in flight
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted word always leads to work or a result
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word dropped");

    // the counter only moves at accept
    a_elapsed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |-> $stable(elapsed_reg))
        else $error("counter moved while busy");

    // the output changes only together with a result
    a_output_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(output_on))
        else $error("output changed without done");

endmodule

[test/window_output_checker.sv]
module window_output_checker #(
    parameter int unsigned SETS  = tws_pkg::SETS_DEF,
    parameter int unsigned FEEDS = tws_pkg::FEEDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          active_set_we,
    input  logic [tws_pkg::SET_W-1:0]     active_set,
    input  logic                          start,
    input  logic                          busy,
    input  logic [tws_pkg::OP_W-1:0]      operation,
    input  logic [tws_pkg::SET_W-1:0]     set_number,
    input  logic [tws_pkg::ENT_W-1:0]     entry_index,
    input  logic [tws_pkg::START_W-1:0]   start_time,
    input  logic [tws_pkg::DUR_W-1:0]     duration,
    input  logic [tws_pkg::COUNT_W-1:0]   entry_count,
    input  logic [tws_pkg::IVAL_W-1:0]    interval,
    input  logic [tws_pkg::PASSED_W-1:0]  seconds_passed,
    input  logic                          done,
    input  logic                          output_on,
    output int unsigned                   mismatch_count,
    output int unsigned                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    // own copy of the schedule table and counter
    logic [START_W-1:0]   win_start [SETS*FEEDS];
    logic [DUR_W-1:0]     win_dur   [SETS*FEEDS];
    logic [ELAPSED_W-1:0] elapsed;
    logic                 lit;
    logic [SET_W-1:0]     set_sel;
    bit                   output_on_due [$];

    function automatic bit set_valid(input logic [SET_W-1:0] s);
        return s >= 1 && s <= SETS;
    endfunction

    task automatic run_tick(input logic [PASSED_W-1:0] passed);
        logic [ELAPSED_W:0] sum;
        logic [START_W:0]   stop;
        int                 base;
        sum = {1'b0, elapsed} + passed;
        elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
        lit = 1'b0;
        if (set_valid(set_sel))
        begin
            base = (set_sel - 1) * FEEDS;
            for (int i = 0; i < FEEDS; i++)
            begin
                if (win_dur[base+i] == '0)
                    break;
                stop = win_start[base+i] + win_dur[base+i];
                if (elapsed >= win_start[base+i] && elapsed < stop)
                begin
                    lit = 1'b1;
                    break;
                end
            end
        end
    endtask

    task automatic run_fill(input logic [SET_W-1:0] s, input logic [COUNT_W-1:0] count,
                            input logic [IVAL_W-1:0] ival, input logic [DUR_W-1:0] dur);
        logic [START_W:0] t;
        int               n;
        int               base;
        if (!set_valid(s))
            return;
        n = (count >= FEEDS) ? FEEDS - 1 : count;
        base = (s - 1) * FEEDS;
        t = '0;
        for (int i = 0; i < FEEDS; i++)
        begin
            if (i < n)
            begin
                win_start[base+i] = t[START_W-1:0];
                win_dur[base+i]   = dur;
                t = t + ival;
                if (t > START_MAX)
                    t = START_MAX;
            end
            else
            begin
                win_start[base+i] = '0;
                win_dur[base+i]   = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit want;
        if (!rst_n)
        begin
            for (int i = 0; i < SETS * FEEDS; i++)
            begin
                win_start[i] = '0;
                win_dur[i]   = '0;
            end
            elapsed = '0;
            lit     = 1'b0;
            set_sel = '0;
            output_on_due.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // result first, so a word can never answer itself
            if (done)
            begin
                if (output_on_due.size() == 0)
                begin
                    $error("output_on: unexpected result word, actual %0b", output_on);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = output_on_due.pop_front();
                    if (output_on !== want)
                    begin
                        $error("output_on mismatch: expected %0b, actual %0b", want, output_on);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (active_set_we)
                set_sel = active_set;
            if (start && !busy)
            begin
                case (operation)
                    OP_TICK:    run_tick(seconds_passed);
                    OP_RESTART: elapsed = '0;
                    OP_WRITE:
                    begin
                        if (set_valid(set_number) && entry_index < FEEDS)
                        begin
                            win_start[(set_number - 1) * FEEDS + entry_index] = start_time;
                            win_dur[(set_number - 1) * FEEDS + entry_index]   = duration;
                        end
                    end
                    default:    run_fill(set_number, entry_count, interval, duration);
                endcase
                output_on_due.push_back(lit);
            end
            outstanding <= output_on_due.size();
        end
    end

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int unsigned SETS        = SETS_DEF;
    localparam int unsigned FEEDS       = FEEDS_DEF;
    // run length limit, in cycles
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // one command word as the sender sees it
    typedef struct {
        logic [OP_W-1:0]     operation;
        logic [SET_W-1:0]    set_number;
        logic [ENT_W-1:0]    entry_index;
        logic [START_W-1:0]  start_time;
        logic [DUR_W-1:0]    duration;
        logic [COUNT_W-1:0]  entry_count;
        logic [IVAL_W-1:0]   interval;
        logic [PASSED_W-1:0] seconds_passed;
    } sched_word_t;

    // every input known from time zero
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                active_set_we  = 1'b0;
    logic [SET_W-1:0]    active_set     = '0;
    logic                start          = 1'b0;
    logic [OP_W-1:0]     operation      = '0;
    logic [SET_W-1:0]    set_number     = '0;
    logic [ENT_W-1:0]    entry_index    = '0;
    logic [START_W-1:0]  start_time     = '0;
    logic [DUR_W-1:0]    duration       = '0;
    logic [COUNT_W-1:0]  entry_count    = '0;
    logic [IVAL_W-1:0]   interval       = '0;
    logic [PASSED_W-1:0] seconds_passed = '0;
    logic                busy;
    logic                done;
    logic                output_on;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned gap_pct = 19;   // chance in a hundred, at each try, that the sender idles before a word
    int unsigned cycles  = 0;

    time_window_schedule_output_top #(
        .SETS  (SETS),
        .FEEDS (FEEDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_set_we  (active_set_we),
        .active_set     (active_set),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .set_number     (set_number),
        .entry_index    (entry_index),
        .start_time     (start_time),
        .duration       (duration),
        .entry_count    (entry_count),
        .interval       (interval),
        .seconds_passed (seconds_passed),
        .done           (done),
        .output_on      (output_on)
    );

    // predicts and compares every result word on its own
    window_output_checker #(
        .SETS  (SETS),
        .FEEDS (FEEDS)
    ) window_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_set_we  (active_set_we),
        .active_set     (active_set),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .set_number     (set_number),
        .entry_index    (entry_index),
        .start_time     (start_time),
        .duration       (duration),
        .entry_count    (entry_count),
        .interval       (interval),
        .seconds_passed (seconds_passed),
        .done           (done),
        .output_on      (output_on),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // fields the operation does not use still carry random bits
    function automatic sched_word_t noise_word();
        sched_word_t w;
        w.operation      = OP_W'($urandom);
        w.set_number     = SET_W'($urandom);
        w.entry_index    = ENT_W'($urandom);
        w.start_time     = START_W'($urandom);
        w.duration       = DUR_W'($urandom);
        w.entry_count    = COUNT_W'($urandom);
        w.interval       = IVAL_W'($urandom);
        w.seconds_passed = PASSED_W'($urandom);
        return w;
    endfunction

    function automatic sched_word_t tick_word(input int unsigned passed);
        sched_word_t w;
        w = noise_word();
        w.operation      = OP_TICK;
        w.seconds_passed = PASSED_W'(passed);
        return w;
    endfunction

    function automatic sched_word_t restart_word();
        sched_word_t w;
        w = noise_word();
        w.operation = OP_RESTART;
        return w;
    endfunction

    function automatic sched_word_t entry_word(input int unsigned s, input int unsigned idx,
                                               input int unsigned st, input int unsigned dur);
        sched_word_t w;
        w = noise_word();
        w.operation   = OP_WRITE;
        w.set_number  = SET_W'(s);
        w.entry_index = ENT_W'(idx);
        w.start_time  = START_W'(st);
        w.duration    = DUR_W'(dur);
        return w;
    endfunction

    function automatic sched_word_t fill_word(input int unsigned s, input int unsigned cnt,
                                              input int unsigned ival, input int unsigned dur);
        sched_word_t w;
        w = noise_word();
        w.operation   = OP_FILL;
        w.set_number  = SET_W'(s);
        w.entry_count = COUNT_W'(cnt);
        w.interval    = IVAL_W'(ival);
        w.duration    = DUR_W'(dur);
        return w;
    endfunction

    // mostly short windows so the small counter keeps landing in and out of them
    function automatic int unsigned random_duration();
        case ($urandom_range(7))
            0:       return 0;
            1:       return $urandom_range(65535);
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    function automatic sched_word_t random_word();
        sched_word_t w;
        int unsigned pick;
        int unsigned s;
        w = noise_word();
        pick = $urandom_range(99);
        // now and then a set number outside the table
        s = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, SETS);
        if (pick < 8)
            w = restart_word();
        else if (pick < 22)
            w = entry_word(s, $urandom_range(15),
                           ($urandom_range(7) == 0) ? $urandom_range(20'hfffff)
                                                    : $urandom_range(400),
                           random_duration());
        else if (pick < 30)
            w = fill_word(s, $urandom_range(15),
                          ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                   : $urandom_range(150),
                          random_duration());
        else
            w = tick_word(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                   : $urandom_range(40));
        return w;
    endfunction

    // present one word and hold it until the block takes it;
    // start stays high afterwards in case the next word follows at once
    task automatic send_word(input sched_word_t w);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        operation      <= w.operation;
        set_number     <= w.set_number;
        entry_index    <= w.entry_index;
        start_time     <= w.start_time;
        duration       <= w.duration;
        entry_count    <= w.entry_count;
        interval       <= w.interval;
        seconds_passed <= w.seconds_passed;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and wait for every expected word to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // register writes only with the block idle; every word answers, so no extra wait
    task automatic write_active_set(input int unsigned v);
        drain();
        while (busy)
            @(posedge clk);
        active_set_we <= 1'b1;
        active_set    <= SET_W'(v);
        @(posedge clk);
        active_set_we <= 1'b0;
    endtask

    task automatic random_items(input int unsigned n);
        int unsigned next_cfg;
        next_cfg = $urandom_range(40, 80);
        for (int unsigned i = 0; i < n; i++)
        begin
            // change the active set now and then, sometimes to a disabled value
            if (i == next_cfg)
            begin
                write_active_set(($urandom_range(5) == 0) ? $urandom_range(7)
                                                          : $urandom_range(1, SETS));
                next_cfg = i + $urandom_range(40, 80);
            end
            send_word(random_word());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // table clearing pass after reset
        while (busy)
            @(posedge clk);

        // directed: empty table, then boundaries of one window
        write_active_set(1);
        send_word(tick_word(0));                       // duration zero ends the scan at once
        send_word(entry_word(1, 0, 0, 16'hffff));      // longest window from time zero
        send_word(tick_word(0));
        send_word(entry_word(1, 1, 20'hfffff, 16'hffff));   // latest start
        send_word(entry_word(0, 2, 0, 50));            // set zero is ignored
        send_word(entry_word(5, 2, 0, 50));            // set above the table is ignored
        send_word(entry_word(7, 2, 0, 50));
        send_word(tick_word(65535));                   // exactly at window end, so off
        send_word(restart_word());                     // output held through restart
        send_word(entry_word(1, 0, 100, 50));
        send_word(tick_word(99));                      // one second early
        send_word(tick_word(1));                       // at the start
        send_word(restart_word());
        send_word(tick_word(149));                     // last second inside
        send_word(tick_word(1));                       // first second past the end

        // directed: cyclic fill with the largest count, spacing and length
        send_word(fill_word(2, 15, 65535, 65535));
        send_word(fill_word(0, 3, 10, 10));            // out of range fills are ignored
        send_word(fill_word(6, 3, 10, 10));
        write_active_set(2);
        send_word(tick_word(0));
        send_word(fill_word(2, 0, 10, 10));            // zero count clears the whole set
        send_word(tick_word(0));

        // directed: last set, entry past the end of the list, disabled selects
        write_active_set(SETS);
        send_word(entry_word(SETS, 15, 0, 1));         // hidden behind an empty entry 0
        send_word(tick_word(0));
        send_word(entry_word(SETS, 0, 0, 16'hffff));
        send_word(restart_word());
        send_word(tick_word(5));
        write_active_set(SETS + 1);                    // select above the table
        send_word(tick_word(0));
        write_active_set(7);
        send_word(tick_word(0));
        write_active_set(0);                           // zero disables the output
        send_word(tick_word(0));

        // random words, three idling profiles
        write_active_set(1);
        random_items(280);
        gap_pct = 82;
        random_items(280);
        gap_pct = 0;
        random_items(260);

        // final drain, then a scan's worth of quiet cycles for stray words
        drain();
        repeat (FEEDS + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hdl/tws_pkg.sv
hdl/time_window_schedule_output_top.sv
test/window_output_checker.sv
test/tb.sv
